// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants and action codes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PCNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam bit DEPTH_POW2  = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

  // Field widths
  localparam int ACT_W  = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int HASH_W = 32;

  // Reciprocal modulo for a depth that is not a power of two:
  // q ~ (h * floor(2^MOD_SHIFT / depth)) >> MOD_SHIFT, then one correction
  localparam int MOD_STEPS = 4;
  localparam int MCNT_W    = $clog2(MOD_STEPS);
  localparam int MOD_SHIFT = HASH_W + IDX_W;
  localparam int MACC_W    = MOD_SHIFT + HASH_W;
  localparam int MDIV_W    = 17;
  localparam logic [63:0]       MOD_RECIP    = (64'd1 << MOD_SHIFT) / 64'(TABLE_DEPTH);
  localparam logic [MDIV_W-1:0] MOD_RECIP_LO = MOD_RECIP[MDIV_W-1:0];
  localparam logic [MDIV_W-1:0] MOD_RECIP_HI = {1'b0, MOD_RECIP[2*MDIV_W-2:MDIV_W]};

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

endpackage

// ===== rtl/lpht_req_if.sv =====
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: action, key bytes and value to store.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic                               valid;
  logic                               ready;
  logic [lpht_pkg::ACT_W-1:0]         action;
  logic [lpht_pkg::KEY_W-1:0]         key_chars;
  logic signed [lpht_pkg::VAL_W-1:0]  new_value;

  modport source (output valid, output action, output key_chars, output new_value,
                  input ready);
  modport sink   (input valid, input action, input key_chars, input new_value,
                  output ready);
endinterface

// ===== rtl/lpht_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: match flag, value read and table-full flag.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [lpht_pkg::VAL_W-1:0]  read_value;
  logic                               table_full;

  modport source (output valid, output found, output read_value, output table_full,
                  input ready);
  modport sink   (input valid, input found, input read_value, input table_full,
                  output ready);
endinterface

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key-to-value table with linear probing, driven by a small
// sequencer around one byte-serial hash unit and one key comparator.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields                              Transaction
//  req      in   action, key_chars, new_value        valid && ready
//  rsp      out  found, read_value, table_full       valid && ready
//
//  Sequence per transaction: accept; a 31*h+c hash step per key byte and a step for the end
//  of key; the multiply-based modulo when the depth is not a power of two; a probe per slot
//  visited (insert) or, on lookup, a registered read then a compare per occupied slot and a
//  probe of a free slot that ends it; the response. Clear and unused actions go straight to it.
//  Reset clears the slot-used flags at once; no clearing pass is needed. req is held off
//  until the response is registered; a stalled rsp holds its transaction meanwhile.
//
module linear_probe_hash_table (
  input  logic       clk,
  input  logic       rst,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]                            state;
  logic [lpht_pkg::ACT_W-1:0]            act;
  logic [lpht_pkg::KEY_W-1:0]            key;
  logic [lpht_pkg::VAL_W-1:0]            val;
  logic [lpht_pkg::KEY_W-1:0]            hsr;
  logic [lpht_pkg::HASH_W-1:0]           h;
  logic [lpht_pkg::IDX_W:0]              rem;
  logic [lpht_pkg::MCNT_W-1:0]           mcnt;
  logic [lpht_pkg::MACC_W-1:0]           macc;
  logic [lpht_pkg::IDX_W-1:0]            idx;
  logic [lpht_pkg::PCNT_W-1:0]           pcnt;
  logic [lpht_pkg::TABLE_DEPTH-1:0]      slot_used;

  logic                                  res_found;
  logic [lpht_pkg::VAL_W-1:0]            res_value;
  logic                                  res_full;

  logic                                  out_valid;
  logic                                  out_found;
  logic [lpht_pkg::VAL_W-1:0]            out_value;
  logic                                  out_full;

  // Key and value store, registered read
  logic [lpht_pkg::KEY_W-1:0]            slot_key   [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::VAL_W-1:0]            slot_value [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0]            rd_key;
  logic [lpht_pkg::VAL_W-1:0]            rd_value;
  logic                                  mem_we;

  logic                                  accept;
  logic [lpht_pkg::KEY_W-1:0]            key_norm;
  logic [7:0]                            hbyte;
  logic [lpht_pkg::HASH_W-1:0]           h_next;
  logic [lpht_pkg::HASH_W-1:0]           quot;
  logic [lpht_pkg::HASH_W-1:0]           mul_a;
  logic [lpht_pkg::MDIV_W-1:0]           mul_b;
  logic [lpht_pkg::HASH_W+lpht_pkg::MDIV_W-1:0] mul_p;
  logic [lpht_pkg::IDX_W:0]              rem_fix;
  logic [lpht_pkg::IDX_W-1:0]            idx_inc;
  logic                                  last_probe;
  logic                                  rsp_free;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp_free = !out_valid || rsp.ready;

  // Keep bytes up to the first zero byte or the byte limit
  always_comb begin
    logic alive;
    alive    = 1'b1;
    key_norm = '0;
    for (int i = 0; i < 8; i++) begin
      if (req.key_chars[63-8*i -: 8] == 8'd0 || i >= lpht_pkg::KEY_BYTES) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_norm[63-8*i -: 8] = req.key_chars[63-8*i -: 8];
      end
    end
  end

  // Hash step: h*31 + c as shift and subtract
  assign hbyte  = hsr[63:56];
  assign h_next = (h << 5) - h + {{(lpht_pkg::HASH_W-8){1'b0}}, hbyte};

  // Shared multiplier for the modulo: two reciprocal halves, then quotient * depth
  assign quot  = macc[lpht_pkg::MOD_SHIFT +: lpht_pkg::HASH_W];
  assign mul_a = (mcnt == lpht_pkg::MCNT_W'(2)) ? quot : h;
  assign mul_b = (mcnt == lpht_pkg::MCNT_W'(0)) ? lpht_pkg::MOD_RECIP_LO
               : (mcnt == lpht_pkg::MCNT_W'(1)) ? lpht_pkg::MOD_RECIP_HI
               : lpht_pkg::MDIV_W'(lpht_pkg::TABLE_DEPTH);
  assign mul_p = {{lpht_pkg::MDIV_W{1'b0}}, mul_a} * {{lpht_pkg::HASH_W{1'b0}}, mul_b};

  // Quotient estimate may be one short: one compare and subtract
  assign rem_fix = (rem >= (lpht_pkg::IDX_W+1)'(lpht_pkg::TABLE_DEPTH))
                 ? rem - (lpht_pkg::IDX_W+1)'(lpht_pkg::TABLE_DEPTH)
                 : rem;

  // Wrapping slot advance and turn limit
  assign idx_inc    = (idx == lpht_pkg::IDX_W'(lpht_pkg::TABLE_DEPTH - 1))
                    ? '0 : idx + 1'b1;
  assign last_probe = (pcnt == lpht_pkg::PCNT_W'(lpht_pkg::TABLE_DEPTH - 1));

  assign mem_we = (state == S_PROBE) && (act == lpht_pkg::ACT_INSERT) && !slot_used[idx];

  // Memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_key[idx]   <= key;
      slot_value[idx] <= val;
    end
    rd_key   <= slot_key[idx];
    rd_value <= slot_value[idx];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_used <= '0;
      out_valid <= 1'b0;
    end else begin
      // Response register drains when taken; S_RESP reloads it
      if (out_valid && rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act       <= req.action;
            key       <= key_norm;
            val       <= req.new_value;
            hsr       <= key_norm;
            h         <= '0;
            pcnt      <= '0;
            res_found <= 1'b0;
            res_value <= '0;
            res_full  <= 1'b0;
            if (req.action == lpht_pkg::ACT_INSERT || req.action == lpht_pkg::ACT_LOOKUP) begin
              state <= S_HASH;
            end else begin
              if (req.action == lpht_pkg::ACT_CLEAR) begin
                slot_used <= '0;
              end
              state <= S_RESP;
            end
          end
        end
        S_HASH: begin
          if (hbyte == 8'd0) begin
            if (lpht_pkg::DEPTH_POW2) begin
              idx   <= h[lpht_pkg::IDX_W-1:0];
              state <= S_PROBE;
            end else begin
              macc  <= '0;
              mcnt  <= '0;
              state <= S_MOD;
            end
          end else begin
            h   <= h_next;
            hsr <= hsr << 8;
          end
        end
        S_MOD: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == lpht_pkg::MCNT_W'(0)) begin
            macc <= lpht_pkg::MACC_W'(mul_p);
          end else if (mcnt == lpht_pkg::MCNT_W'(1)) begin
            macc <= macc + lpht_pkg::MACC_W'({mul_p, {lpht_pkg::MDIV_W{1'b0}}});
          end else if (mcnt == lpht_pkg::MCNT_W'(2)) begin
            rem <= (lpht_pkg::IDX_W+1)'(h - mul_p[lpht_pkg::HASH_W-1:0]);
          end else begin
            idx   <= rem_fix[lpht_pkg::IDX_W-1:0];
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (act == lpht_pkg::ACT_INSERT) begin
            if (!slot_used[idx]) begin
              slot_used[idx] <= 1'b1;
              res_found      <= 1'b1;
              state          <= S_RESP;
            end else if (last_probe) begin
              res_full <= 1'b1;
              state    <= S_RESP;
            end else begin
              idx  <= idx_inc;
              pcnt <= pcnt + 1'b1;
            end
          end else begin
            // Lookup: a free slot ends the search
            if (!slot_used[idx]) begin
              res_value <= '1;
              state     <= S_RESP;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (rd_key == key) begin
            res_found <= 1'b1;
            res_value <= rd_value;
            state     <= S_RESP;
          end else if (last_probe) begin
            res_value <= '1;
            state     <= S_RESP;
          end else begin
            idx   <= idx_inc;
            pcnt  <= pcnt + 1'b1;
            state <= S_PROBE;
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            out_valid <= 1'b1;
            out_found <= res_found;
            out_value <= res_value;
            out_full  <= res_full;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.read_value = out_value;
  assign rsp.table_full = out_full;

`ifndef NO_ASSERTIONS
  // An accepted request always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // Insert success and full table are exclusive
  a_found_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_found && out_full))
    else $error("response flags both found and table full");

  // Memory writes only from an insert probe onto a free slot
  a_we_insert_only: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> slot_used[$past(idx)] && state == S_RESP)
    else $error("memory write without slot claim");

  // Clear has emptied the table by the cycle after it is accepted
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == lpht_pkg::ACT_CLEAR |=> slot_used == '0)
    else $error("clear left occupied slots");

  // A new response is never loaded over one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |=> out_valid && $stable(out_value))
    else $error("held response overwritten");
`endif

endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. Requests go in
// through a valid/ready source with random gaps. Replies are checked field by
// field against an in-bench model of the slot array, which is updated at each
// accepted request. Directed cases come first, then a fill to overflow, a long
// random mix and a back-pressure burst.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;

  // Action code that the block ignores
  localparam logic [lpht_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int HOLD_CYCLES = 400;   // long receiver stall for the pressure test
  localparam int STALL_LIMIT = 4000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 200;   // settle time once nothing is outstanding

  typedef struct {
    logic                              found;
    logic signed [lpht_pkg::VAL_W-1:0] read_value;
    logic                              table_full;
  } reply_t;

  logic clk;
  logic rst;

  lpht_req_if req_ch ();
  lpht_rsp_if rsp_ch ();

  linear_probe_hash_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Model of the slot array
  bit                         occupied   [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0] stored_key [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::VAL_W-1:0] stored_val [lpht_pkg::TABLE_DEPTH];

  reply_t                     expected_replies[$];
  logic [lpht_pkg::KEY_W-1:0] known_keys[$];
  int                         fail_count    = 0;
  int                         tx_idle_pct   = 20;
  int                         rx_idle_pct   = 20;
  int                         hold_requests = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------

  // Keep bytes up to the first zero or the byte limit
  function automatic logic [lpht_pkg::KEY_W-1:0] normalise_key(
      logic [lpht_pkg::KEY_W-1:0] raw);
    logic [lpht_pkg::KEY_W-1:0] kept;
    logic [7:0]                 b;
    bit                         ended;
    kept  = '0;
    ended = 1'b0;
    for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
      b = raw[lpht_pkg::KEY_W-8-8*i +: 8];
      if (b == 8'd0) ended = 1'b1;
      if (!ended) kept[lpht_pkg::KEY_W-8-8*i +: 8] = b;
    end
    return kept;
  endfunction

  // 31*h+c over unsigned bytes, wrapping at 32 bits
  function automatic int home_slot(logic [lpht_pkg::KEY_W-1:0] key);
    logic [lpht_pkg::HASH_W-1:0] h;
    logic [7:0]                  b;
    bit                          ended;
    h     = '0;
    ended = 1'b0;
    for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
      b = key[lpht_pkg::KEY_W-8-8*i +: 8];
      if (b == 8'd0) ended = 1'b1;
      if (!ended) h = h * 32'd31 + {24'd0, b};
    end
    return int'(h % lpht_pkg::TABLE_DEPTH);
  endfunction

  // Apply one accepted transaction to the model and return its reply
  function automatic reply_t predict_table(logic [lpht_pkg::ACT_W-1:0] act,
                                           logic [lpht_pkg::KEY_W-1:0] raw,
                                           logic [lpht_pkg::VAL_W-1:0] value);
    reply_t                     res;
    logic [lpht_pkg::KEY_W-1:0] key;
    int                         slot;
    bit                         done;
    res.found      = 1'b0;
    res.read_value = '0;
    res.table_full = 1'b0;
    key  = normalise_key(raw);
    slot = home_slot(key);
    done = 1'b0;
    case (act)
      lpht_pkg::ACT_INSERT: begin
        for (int n = 0; n < lpht_pkg::TABLE_DEPTH && !done; n++) begin
          if (!occupied[slot]) begin
            occupied[slot]   = 1'b1;
            stored_key[slot] = key;
            stored_val[slot] = value;
            res.found        = 1'b1;
            done             = 1'b1;
          end else begin
            slot = (slot + 1) % lpht_pkg::TABLE_DEPTH;
          end
        end
        res.table_full = !done;
      end
      lpht_pkg::ACT_LOOKUP: begin
        res.read_value = -1;
        for (int n = 0; n < lpht_pkg::TABLE_DEPTH && !done; n++) begin
          if (!occupied[slot]) begin
            done = 1'b1;
          end else if (stored_key[slot] == key) begin
            res.found      = 1'b1;
            res.read_value = stored_val[slot];
            done           = 1'b1;
          end else begin
            slot = (slot + 1) % lpht_pkg::TABLE_DEPTH;
          end
        end
      end
      lpht_pkg::ACT_CLEAR: begin
        occupied = '{default: 1'b0};
      end
      default: ;
    endcase
    return res;
  endfunction

  // Key of len nonzero bytes from 1..max_byte; junk after the terminator when junk is set
  function automatic logic [lpht_pkg::KEY_W-1:0] random_key(int len, int max_byte, bit junk);
    logic [lpht_pkg::KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < len) k[lpht_pkg::KEY_W-8-8*i +: 8] = 8'($urandom_range(max_byte, 1));
      else if (i > len && junk) k[lpht_pkg::KEY_W-8-8*i +: 8] = 8'($urandom_range(255, 0));
    end
    return k;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: random gaps, then hold until the transaction is taken
  // --------------------------------------------------------------------------
  task automatic issue_request(logic [lpht_pkg::ACT_W-1:0] act,
                               logic [lpht_pkg::KEY_W-1:0] key,
                               logic [lpht_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.key_chars <= key;
    req_ch.new_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_replies.push_back(predict_table(act, key, value));
  endtask

  // --------------------------------------------------------------------------
  // Reply side: check each transaction, then drive ready
  // --------------------------------------------------------------------------
  initial begin
    reply_t want;
    int     hold_seen;
    int     hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (rsp_ch.found !== want.found)
            report_mismatch($sformatf("found got %b want %b", rsp_ch.found, want.found));
          if (rsp_ch.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      rsp_ch.read_value, want.read_value));
          if (rsp_ch.table_full !== want.table_full)
            report_mismatch($sformatf("table_full got %b want %b",
                                      rsp_ch.table_full, want.table_full));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: too long with no transaction on either channel
  initial begin
    int stall_count;
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        stall_count = 0;
      else
        stall_count++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, normalisation, empty key, collisions, wrap, duplicates
  task automatic test_directed();
    issue_request(lpht_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    issue_request(lpht_pkg::ACT_INSERT, 64'h0101_0101_0101_0101, 32'h8000_0000);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h0101_0101_0101_0101, 32'hFFFF_FFFF);
    // empty key, looked up with junk after the leading zero
    issue_request(lpht_pkg::ACT_INSERT, 64'h0, 32'd5);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
    // junk after terminator is ignored on insert
    issue_request(lpht_pkg::ACT_INSERT, 64'h4142_00DE_ADBE_EF55, 32'd77);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h4142_0000_0000_0000, 32'h0);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h4142_4300_0000_0000, 32'h0);
    // duplicates: the earliest copy wins
    issue_request(lpht_pkg::ACT_INSERT, 64'h6475_7000_0000_0000, 32'd1);
    issue_request(lpht_pkg::ACT_INSERT, 64'h6475_7000_0000_0000, 32'd2);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h6475_7000_0000_0000, 32'h0);
    // same home slot, including a high byte
    issue_request(lpht_pkg::ACT_INSERT, 64'h4100_0000_0000_0000, 32'd10);
    issue_request(lpht_pkg::ACT_INSERT, 64'h8100_0000_0000_0000, 32'd11);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'hC100_0000_0000_0000, 32'h0);
    // home slot at the top, probing wraps round
    issue_request(lpht_pkg::ACT_INSERT, 64'h3F00_0000_0000_0000, 32'd20);
    issue_request(lpht_pkg::ACT_INSERT, 64'h7F00_0000_0000_0000, 32'd21);
    issue_request(lpht_pkg::ACT_INSERT, 64'hBF00_0000_0000_0000, 32'd22);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'hBF00_0000_0000_0000, 32'h0);
    // unused action leaves the table alone
    issue_request(ACT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h8100_0000_0000_0000, 32'h0);
    issue_request(lpht_pkg::ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    issue_request(lpht_pkg::ACT_INSERT, 64'h4100_0000_0000_0000, 32'h0);
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h4100_0000_0000_0000, 32'h0);
  endtask

  // Fill every slot, overflow it, then probe a full table
  task automatic test_full_table();
    logic [lpht_pkg::KEY_W-1:0] filled[$];
    logic [lpht_pkg::KEY_W-1:0] key;
    issue_request(lpht_pkg::ACT_CLEAR, '0, '0);
    for (int i = 0; i < lpht_pkg::TABLE_DEPTH; i++) begin
      key = random_key($urandom_range(8, 1), 255, $urandom_range(1));
      filled.push_back(key);
      issue_request(lpht_pkg::ACT_INSERT, key, $urandom);
    end
    issue_request(lpht_pkg::ACT_INSERT, random_key(3, 255, 1'b0), $urandom);
    // the empty key cannot be present: a full turn with no match
    issue_request(lpht_pkg::ACT_LOOKUP, 64'h0, $urandom);
    issue_request(lpht_pkg::ACT_LOOKUP, filled[lpht_pkg::TABLE_DEPTH-1], $urandom);
    issue_request(lpht_pkg::ACT_LOOKUP, filled[0], $urandom);
    for (int i = 0; i < 4; i++)
      issue_request(lpht_pkg::ACT_LOOKUP, filled[$urandom_range(lpht_pkg::TABLE_DEPTH-1)],
                    $urandom);
    issue_request(lpht_pkg::ACT_CLEAR, '0, '0);
    issue_request(lpht_pkg::ACT_LOOKUP, filled[0], $urandom);
  endtask

  // Random mix; lookups mostly reuse earlier keys so that they hit
  task automatic test_random(int count);
    int                         r;
    logic [lpht_pkg::KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      tx_idle_pct = (i >= 300 && i < 450) ? 0 : 20;
      rx_idle_pct = tx_idle_pct;
      r = $urandom_range(99);
      if (r < 1) begin
        issue_request(lpht_pkg::ACT_CLEAR, {$urandom, $urandom}, $urandom);
      end else if (r < 3) begin
        issue_request(ACT_UNUSED, {$urandom, $urandom}, $urandom);
      end else if (r < 50) begin
        // narrow alphabet gives duplicates and clustering
        if ($urandom_range(2) == 0)
          key = random_key($urandom_range(2, 0), 4, $urandom_range(1));
        else
          key = random_key($urandom_range(8, 0), 255, $urandom_range(1));
        known_keys.push_back(key);
        if (known_keys.size() > 96) void'(known_keys.pop_front());
        issue_request(lpht_pkg::ACT_INSERT, key, $urandom);
      end else begin
        if (known_keys.size() > 0 && $urandom_range(9) < 7)
          key = known_keys[$urandom_range(known_keys.size() - 1)];
        else
          key = random_key($urandom_range(8, 0), 255, $urandom_range(1));
        issue_request(lpht_pkg::ACT_LOOKUP, key, $urandom);
      end
    end
    tx_idle_pct = 20;
    rx_idle_pct = 20;
  endtask

  // Receiver holds off while requests keep coming; input must stall
  task automatic test_backpressure();
    tx_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0)
        issue_request(lpht_pkg::ACT_INSERT, random_key($urandom_range(8, 1), 255, 1'b1),
                      $urandom);
      else
        issue_request(lpht_pkg::ACT_LOOKUP, random_key($urandom_range(2, 0), 4, 1'b0),
                      $urandom);
    end
    tx_idle_pct = 20;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= '0;
    req_ch.key_chars <= '0;
    req_ch.new_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_random(1020);
    test_backpressure();
    req_ch.valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
